/* rtl/core/lgsd_pkg.sv */
`timescale 1ns / 1ps

package lgsd_pkg;

    // opcodes of an input item
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_SAMPLE  = 2'd1;
    localparam logic [1:0] OP_TRIGGER = 2'd2;
    localparam logic [1:0] OP_ACK     = 2'd3;

    // report kinds
    localparam logic KIND_TRIGGER = 1'b0;
    localparam logic KIND_RESULT  = 1'b1;

    // register indexes on the config port
    localparam logic [1:0] REG_HIT_LIMIT      = 2'd0;
    localparam logic [1:0] REG_WINDOW_SAMPLES = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE_MS    = 2'd2;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register reset values
    localparam logic [11:0] HIT_LIMIT_RST      = 12'd1000;
    localparam logic [8:0]  WINDOW_SAMPLES_RST = 9'd240;
    localparam logic [15:0] DEBOUNCE_MS_RST    = 16'd200;

    // ambient averaging over a power-of-two run of recent samples
    localparam int AMBIENT_SHIFT = 3;
    localparam int AMBIENT_DEPTH = 1 << AMBIENT_SHIFT;
    localparam int SUM_W         = 12 + AMBIENT_SHIFT;

    localparam logic [11:0] SAMPLE_MAX = 12'hFFF;

    typedef struct packed {
        logic [11:0] hit_limit;
        logic [8:0]  window_samples;
        logic [15:0] debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] light_sample;
        logic [31:0] ack_sequence;
    } item_t;

    typedef struct packed {
        logic        report_kind;
        logic [31:0] shot_sequence;
        logic [11:0] ambient_level;
        logic [11:0] peak_level;
        logic        hit_flag;
        logic        last_of_run;
    } result_t;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        result_t first;
        result_t second;
    } push_t;

endpackage

/* rtl/core/lgsd_regs.sv */
`timescale 1ns / 1ps

module lgsd_regs
    import lgsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hit_limit      <= HIT_LIMIT_RST;
            cfg_reg.window_samples <= WINDOW_SAMPLES_RST;
            cfg_reg.debounce_ms    <= DEBOUNCE_MS_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_HIT_LIMIT:      cfg_reg.hit_limit      <= pwdata[11:0];
                REG_WINDOW_SAMPLES: cfg_reg.window_samples <= pwdata[8:0];
                REG_DEBOUNCE_MS:    cfg_reg.debounce_ms    <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_HIT_LIMIT:      prdata = {20'd0, cfg_reg.hit_limit};
            REG_WINDOW_SAMPLES: prdata = {23'd0, cfg_reg.window_samples};
            REG_DEBOUNCE_MS:    prdata = {16'd0, cfg_reg.debounce_ms};
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/lgsd_core.sv */
`timescale 1ns / 1ps

module lgsd_core
    import lgsd_pkg::*;
#(
    parameter int MAX_WINDOW = 256
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  fire,
    input  item_t item,
    output push_t push
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int LEN_W = (CNT_W > 9) ? CNT_W : 9;
    localparam int POS_W = AMBIENT_SHIFT;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_WAIT   = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;

    logic [1:0]       mode_reg,    mode_next;
    logic [31:0]      ms_reg,      ms_next;
    logic [31:0]      last_reg,    last_next;
    logic             pending_reg, pending_next;
    logic [31:0]      seq_reg,     seq_next;
    logic [SUM_W-1:0] sum_reg,     sum_next;
    logic [CNT_W-1:0] cnt_reg,     cnt_next;
    logic [11:0]      min_reg,     min_next;
    logic [POS_W-1:0] pos_reg,     pos_next;
    logic [11:0]      recent_reg [AMBIENT_DEPTH];

    logic [LEN_W-1:0] ws_ext;
    logic [LEN_W-1:0] win_len;
    logic [31:0]      ms_gap;
    logic             res_valid;
    logic             trig_valid;
    result_t          res_item;
    result_t          trig_item;

    // window length: zero acts as one, saturated to the largest window
    always_comb
    begin
        ws_ext = LEN_W'(cfg.window_samples);
        if (ws_ext == '0)
            win_len = LEN_W'(1);
        else if (ws_ext > LEN_W'(MAX_WINDOW))
            win_len = LEN_W'(MAX_WINDOW);
        else
            win_len = ws_ext;
    end

    assign ms_gap = ms_reg - last_reg;

    always_comb
    begin
        mode_next    = mode_reg;
        ms_next      = ms_reg;
        last_next    = last_reg;
        pending_next = pending_reg;
        seq_next     = seq_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        min_next     = min_reg;
        pos_next     = pos_reg;
        res_valid    = 1'b0;
        trig_valid   = 1'b0;

        case (item.opcode)
            OP_TICK:
            begin
                ms_next = ms_reg + 32'd1;
            end
            OP_SAMPLE:
            begin
                sum_next = sum_reg - SUM_W'(recent_reg[pos_reg])
                         + SUM_W'(item.light_sample);
                pos_next = pos_reg + POS_W'(1);
                if (mode_reg == MODE_SAMPLE)
                begin
                    if (item.light_sample < min_reg)
                        min_next = item.light_sample;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (LEN_W'(cnt_next) >= win_len)
                    begin
                        res_valid = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
            end
            OP_TRIGGER:
            begin
                if (ms_gap > {16'd0, cfg.debounce_ms})
                begin
                    pending_next = 1'b1;
                    last_next    = ms_reg;
                end
            end
            OP_ACK:
            begin
                if (item.ack_sequence != 32'd0 && item.ack_sequence == seq_reg
                    && mode_reg == MODE_WAIT)
                begin
                    mode_next = MODE_SAMPLE;
                    cnt_next  = '0;
                    min_next  = SAMPLE_MAX;
                end
            end
            default:
            begin
            end
        endcase

        // idle with a trigger waiting: start the next shot
        if (mode_next == MODE_IDLE && pending_next)
        begin
            pending_next = 1'b0;
            seq_next     = seq_reg + 32'd1;
            mode_next    = MODE_WAIT;
            trig_valid   = 1'b1;
        end
    end

    always_comb
    begin
        res_item.report_kind   = KIND_RESULT;
        res_item.shot_sequence = seq_reg;
        res_item.ambient_level = 12'd0;
        res_item.peak_level    = min_next;
        res_item.hit_flag      = (min_next < cfg.hit_limit);
        res_item.last_of_run   = !trig_valid;

        trig_item.report_kind   = KIND_TRIGGER;
        trig_item.shot_sequence = seq_next;
        trig_item.ambient_level = sum_next[SUM_W-1:AMBIENT_SHIFT];
        trig_item.peak_level    = 12'd0;
        trig_item.hit_flag      = 1'b0;
        trig_item.last_of_run   = 1'b1;

        push.first_valid  = fire && (res_valid || trig_valid);
        push.second_valid = fire && res_valid && trig_valid;
        push.first        = res_valid ? res_item : trig_item;
        push.second       = trig_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            ms_reg      <= '0;
            last_reg    <= '0;
            pending_reg <= 1'b0;
            seq_reg     <= '0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            min_reg     <= SAMPLE_MAX;
            pos_reg     <= '0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            ms_reg      <= ms_next;
            last_reg    <= last_next;
            pending_reg <= pending_next;
            seq_reg     <= seq_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            min_reg     <= min_next;
            pos_reg     <= pos_next;
        end
    end

    // recent samples ring, cleared by reset so early means count zeros
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AMBIENT_DEPTH; i++)
                recent_reg[i] <= '0;
        end
        else if (fire && item.opcode == OP_SAMPLE)
        begin
            recent_reg[pos_reg] <= item.light_sample;
        end
    end

endmodule

/* rtl/core/lgsd_fifo.sv */
`timescale 1ns / 1ps

module lgsd_fifo
    import lgsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room2,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg,  count_next;
    logic             pop;
    logic [PTR_W:0]   push_n;

    assign room2     = (count_reg <= (PTR_W + 1)'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        push_n      = (PTR_W + 1)'(push.first_valid) + (PTR_W + 1)'(push.second_valid);
        wr_ptr_next = wr_ptr_reg + push_n[PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + push_n - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
            mem[wr_ptr_reg] <= push.first;
        if (push.second_valid)
            mem[wr_ptr_reg + PTR_W'(1)] <= push.second;
    end

endmodule

/* rtl/core/light_gun_shot_detector_unit.sv */
`timescale 1ns / 1ps

// light-gun shot sequencer: items are millisecond ticks, light samples,
// trigger edges and acknowledges; a debounced trigger starts a shot and gives
// a trigger report with the ambient level (mean of the last eight samples),
// and the matching acknowledge opens a window whose minimum sample becomes a
// result report with a hit flag. one input transfer is taken per clock while
// in_stall is low: the item lands in an input register and is processed from
// there once the report queue has room for two reports. an item makes zero,
// one or two reports; reports go through a four-entry queue, and the input is
// stalled only while that queue has fewer than two free entries, so sustained
// rate is one item per cycle while the output side keeps taking transfers.
// config writes go through the apb-style port at byte offsets 0 (hit_limit),
// 4 (window_samples), 8 (debounce_ms). MAX_WINDOW caps the window length.

module light_gun_shot_detector_unit
    import lgsd_pkg::*;
#(
    parameter int MAX_WINDOW = 256
)
(
    input  logic               clk,
    input  logic               rst_n,

    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [11:0]        light_sample,
    input  logic [31:0]        ack_sequence,

    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               report_kind,
    output logic [31:0]        shot_sequence,
    output logic [11:0]        ambient_level,
    output logic [11:0]        peak_level,
    output logic               hit_flag,
    output logic               last_of_run
);

    cfg_t    cfg;
    push_t   push;
    result_t out_item;
    logic    room2;

    // input register stage
    item_t   item_reg;
    logic    item_valid_reg, item_valid_next;
    logic    in_take;
    logic    fire;

    // item is processed once the queue can hold both of its reports
    assign fire     = item_valid_reg && room2;
    assign in_stall = item_valid_reg && !room2;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = in_take || (item_valid_reg && !fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.opcode       <= opcode;
            item_reg.light_sample <= light_sample;
            item_reg.ack_sequence <= ack_sequence;
        end
    end

    lgsd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lgsd_core #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (fire),
        .item  (item_reg),
        .push  (push)
    );

    // report queue, one output transfer per entry
    lgsd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room2     (room2),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    assign report_kind   = out_item.report_kind;
    assign shot_sequence = out_item.shot_sequence;
    assign ambient_level = out_item.ambient_level;
    assign peak_level    = out_item.peak_level;
    assign hit_flag      = out_item.hit_flag;
    assign last_of_run   = out_item.last_of_run;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import lgsd_pkg::*;

    // overall cycle budget, far above the slowest legal run
    localparam int RUN_LIMIT  = 400000;
    // window length cap of the block under test
    localparam int WINDOW_CAP = 256;

    // shot sequencer states as the predictor tracks them
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WAIT,
        MODE_SAMPLE
    } shot_mode_e;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         opcode = OP_TICK;
    logic [11:0]        light_sample = '0;
    logic [31:0]        ack_sequence = '0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               report_kind;
    logic [31:0]        shot_sequence;
    logic [11:0]        ambient_level;
    logic [11:0]        peak_level;
    logic               hit_flag;
    logic               last_of_run;

    // items waiting to be driven, and reports the block still owes us
    item_t   shot_items[$];
    result_t expected_reports[$];
    item_t   next_item;
    result_t next_report;

    // percentage of cycles the sender holds off and the receiver stalls
    int send_gap_pct = 0;
    int recv_stall_pct = 0;

    int item_total = 0;
    int error_count = 0;
    int cycle_count = 0;

    // predictor copy of the register file
    cfg_t cur_cfg = '{HIT_LIMIT_RST, WINDOW_SAMPLES_RST, DEBOUNCE_MS_RST};

    // predictor copy of the sequencer state
    shot_mode_e               shot_mode = MODE_IDLE;
    logic [31:0]              tick_count = '0;
    logic [31:0]              last_edge_ms = '0;
    logic                     edge_pending = 1'b0;
    logic [31:0]              shot_seq = '0;
    logic [11:0]              light_hist[AMBIENT_DEPTH] = '{default: '0};
    logic [AMBIENT_SHIFT-1:0] hist_wr = '0;
    logic [SUM_W-1:0]         hist_sum = '0;
    logic [8:0]               win_seen = '0;
    logic [11:0]              win_low = SAMPLE_MAX;

    light_gun_shot_detector_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .light_sample  (light_sample),
        .ack_sequence  (ack_sequence),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .report_kind   (report_kind),
        .shot_sequence (shot_sequence),
        .ambient_level (ambient_level),
        .peak_level    (peak_level),
        .hit_flag      (hit_flag),
        .last_of_run   (last_of_run)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // effective window length: zero acts as one, long settings saturate
    function automatic int window_len(logic [8:0] setting);
        if (setting == 9'd0)
            return 1;
        if (setting > WINDOW_CAP)
            return WINDOW_CAP;
        return setting;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("ERROR cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
    endtask

    // advance the sequencer by one accepted item and queue the reports it makes
    function automatic void apply_item(item_t it);
        result_t     rep[2];
        int          n;
        logic [31:0] gap;
        n = 0;
        rep[0] = '0;
        rep[1] = '0;
        case (it.opcode)
            OP_TICK:
                tick_count = tick_count + 32'd1;
            OP_SAMPLE:
            begin
                // running sum over the ambient history
                hist_sum = hist_sum - SUM_W'(light_hist[hist_wr]) + SUM_W'(it.light_sample);
                light_hist[hist_wr] = it.light_sample;
                hist_wr = hist_wr + 1'b1;
                if (shot_mode == MODE_SAMPLE)
                begin
                    if (it.light_sample < win_low)
                        win_low = it.light_sample;
                    win_seen = win_seen + 9'd1;
                    if (win_seen >= window_len(cur_cfg.window_samples))
                    begin
                        rep[n].report_kind   = KIND_RESULT;
                        rep[n].shot_sequence = shot_seq;
                        rep[n].peak_level    = win_low;
                        rep[n].hit_flag      = (win_low < cur_cfg.hit_limit);
                        n++;
                        shot_mode = MODE_IDLE;
                    end
                end
            end
            OP_TRIGGER:
            begin
                gap = tick_count - last_edge_ms;
                if (gap > {16'd0, cur_cfg.debounce_ms})
                begin
                    edge_pending = 1'b1;
                    last_edge_ms = tick_count;
                end
            end
            default:
            begin
                if (it.ack_sequence != 32'd0 && it.ack_sequence == shot_seq &&
                    shot_mode == MODE_WAIT)
                begin
                    shot_mode = MODE_SAMPLE;
                    win_seen  = '0;
                    win_low   = SAMPLE_MAX;
                end
            end
        endcase
        // an idle sequencer takes a latched trigger after the item itself
        if (shot_mode == MODE_IDLE && edge_pending)
        begin
            edge_pending = 1'b0;
            shot_seq = shot_seq + 32'd1;
            shot_mode = MODE_WAIT;
            rep[n].report_kind   = KIND_TRIGGER;
            rep[n].shot_sequence = shot_seq;
            rep[n].ambient_level = 12'(hist_sum >> AMBIENT_SHIFT);
            n++;
        end
        if (n > 0)
            rep[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            expected_reports.push_back(rep[i]);
    endfunction

    // the field that matters takes val, the others carry junk
    task automatic push_item(logic [1:0] op, logic [31:0] val);
        item_t it;
        it.opcode       = op;
        it.light_sample = (op == OP_SAMPLE) ? val[11:0] : 12'($urandom);
        it.ack_sequence = (op == OP_ACK) ? val : 32'($urandom);
        shot_items.push_back(it);
        item_total++;
    endtask

    // sample values lean to the extremes and to the hit threshold
    function automatic logic [11:0] pick_sample();
        logic [11:0] s;
        case ($urandom_range(7))
            0:       s = 12'd0;
            1:       s = SAMPLE_MAX;
            2, 3:    s = cur_cfg.hit_limit + 12'($urandom_range(4)) - 12'd2;
            default: s = 12'($urandom);
        endcase
        return s;
    endfunction

    // wait at a falling edge until every item is taken (and every report, if asked)
    task automatic wait_drained(bit with_reports);
        @(negedge clk);
        while (shot_items.size() != 0 || in_valid ||
               (with_reports && expected_reports.size() != 0))
            @(negedge clk);
    endtask

    // write one register with junk above its field, then read it back
    task automatic program_register(logic [1:0] idx, logic [31:0] field);
        logic [31:0] mask;
        logic [31:0] readback;
        int          rd;
        mask = (idx == REG_HIT_LIMIT)      ? 32'h0FFF :
               (idx == REG_WINDOW_SAMPLES) ? 32'h01FF : 32'hFFFF;
        readback = '0;
        for (rd = 0; rd < 2; rd++)
        begin
            @(posedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= (rd == 0);
            paddr   <= {idx, 2'b00};
            pwdata  <= (32'($urandom) & ~mask) | (field & mask);
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            readback = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
        end
        if (readback !== (field & mask))
            report_mismatch("register readback", readback, field & mask);
        case (idx)
            REG_HIT_LIMIT:      cur_cfg.hit_limit      = field[11:0];
            REG_WINDOW_SAMPLES: cur_cfg.window_samples = field[8:0];
            default:            cur_cfg.debounce_ms    = field[15:0];
        endcase
    endtask

    // registers change only once the block has gone quiet
    task automatic apply_settings(logic [31:0] thr, logic [31:0] win, logic [31:0] deb);
        wait_drained(1);
        repeat (6) @(posedge clk);
        program_register(REG_HIT_LIMIT, thr);
        program_register(REG_WINDOW_SAMPLES, win);
        program_register(REG_DEBOUNCE_MS, deb);
        @(negedge clk);
    endtask

    // one well-formed shot from wherever the sequencer stands, or a burst of noise
    task automatic play_shot();
        logic [31:0] gap;
        logic [31:0] target;
        int          n_ticks;
        int          n_win;
        int          rest;
        bit          fired;
        wait_drained(0);
        if ($urandom_range(99) < 20)
        begin
            repeat ($urandom_range(6, 1))
                push_item(2'($urandom_range(3)), 32'($urandom));
            return;
        end
        n_win = window_len(cur_cfg.window_samples);
        if (shot_mode == MODE_SAMPLE)
        begin
            // finish a window left open earlier
            rest = n_win - int'(win_seen);
            if (rest < 1)
                rest = 1;
            repeat (rest) push_item(OP_SAMPLE, 32'(pick_sample()));
            return;
        end
        if (shot_mode == MODE_IDLE)
        begin
            repeat ($urandom_range(9)) push_item(OP_SAMPLE, 32'(pick_sample()));
            gap = tick_count - last_edge_ms;
            // enough ticks to clear the debounce, unless it is long or we want a bounce
            if (gap > cur_cfg.debounce_ms || cur_cfg.debounce_ms - gap > 40 ||
                $urandom_range(9) == 0)
                n_ticks = $urandom_range(3);
            else
                n_ticks = cur_cfg.debounce_ms - gap + 1 + $urandom_range(2);
            repeat (n_ticks) push_item(OP_TICK, 32'($urandom));
            fired = (gap + n_ticks) > cur_cfg.debounce_ms;
            push_item(OP_TRIGGER, 32'($urandom));
            if (!fired)
                return;
            target = shot_seq + 32'd1;
        end
        else
            target = shot_seq;
        // stale or unparsable acknowledge ahead of the real one
        if ($urandom_range(99) < 30)
            push_item(OP_ACK, $urandom_range(1) ? 32'd0 : target + 32'd1 + $urandom_range(5));
        if ($urandom_range(99) < 8)
            return;
        push_item(OP_ACK, target);
        if ($urandom_range(99) < 10)
            n_win = n_win - 1;
        for (int i = 0; i < n_win; i++)
        begin
            if ($urandom_range(99) < 8)
                push_item(OP_TICK, 32'($urandom));
            // acknowledge while sampling is ignored
            if ($urandom_range(99) < 4)
                push_item(OP_ACK, target);
            // a trigger latched inside the window fires right after the result
            if (i == n_win - 1 && $urandom_range(99) < 25)
            begin
                if (cur_cfg.debounce_ms <= 20)
                    repeat (cur_cfg.debounce_ms + 1) push_item(OP_TICK, 32'($urandom));
                push_item(OP_TRIGGER, 32'($urandom));
            end
            push_item(OP_SAMPLE, 32'(pick_sample()));
        end
    endtask

    // driver: next item goes out once the current transfer is done
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (shot_items.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                next_item = shot_items.pop_front();
                in_valid     <= 1'b1;
                opcode       <= next_item.opcode;
                light_sample <= next_item.light_sample;
                ack_sequence <= next_item.ack_sequence;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: predict on each input transfer, check each output transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                apply_item({opcode, light_sample, ack_sequence});
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                    report_mismatch("report with none expected", shot_sequence, 32'd0);
                else
                begin
                    next_report = expected_reports.pop_front();
                    if (report_kind !== next_report.report_kind)
                        report_mismatch("report_kind", report_kind, next_report.report_kind);
                    if (shot_sequence !== next_report.shot_sequence)
                        report_mismatch("shot_sequence", shot_sequence,
                                        next_report.shot_sequence);
                    if (ambient_level !== next_report.ambient_level)
                        report_mismatch("ambient_level", ambient_level,
                                        next_report.ambient_level);
                    if (peak_level !== next_report.peak_level)
                        report_mismatch("peak_level", peak_level, next_report.peak_level);
                    if (hit_flag !== next_report.hit_flag)
                        report_mismatch("hit_flag", hit_flag, next_report.hit_flag);
                    if (last_of_run !== next_report.last_of_run)
                        report_mismatch("last_of_run", last_of_run, next_report.last_of_run);
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("light_gun_shot_detector_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        int p;
        int budget_end;
        logic [31:0] thr;
        logic [31:0] win;
        logic [31:0] deb;
        logic [31:0] budget;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        send_gap_pct = 18;
        recv_stall_pct = 70;
        apply_settings(32'd2048, 32'd2, 32'd3);

        // directed: ambient from extreme samples, a clean shot, a bounced edge,
        // ignored zero and wrong-sequence acknowledges, a trigger latched mid-window so the
        // result and the next trigger report share one item, then a miss
        push_item(OP_SAMPLE, 32'd4095);
        push_item(OP_SAMPLE, 32'd0);
        repeat (4) push_item(OP_TICK, 32'($urandom));
        push_item(OP_TRIGGER, 32'($urandom));
        push_item(OP_TRIGGER, 32'($urandom));
        push_item(OP_ACK, 32'd0);
        push_item(OP_ACK, 32'd2);
        push_item(OP_ACK, 32'hFFFF_FFFF);
        push_item(OP_ACK, 32'd1);
        push_item(OP_SAMPLE, 32'd4095);
        repeat (4) push_item(OP_TICK, 32'($urandom));
        push_item(OP_TRIGGER, 32'($urandom));
        push_item(OP_SAMPLE, 32'd2047);
        push_item(OP_ACK, 32'd1);
        push_item(OP_ACK, 32'd2);
        push_item(OP_SAMPLE, 32'd2048);
        push_item(OP_SAMPLE, 32'd3000);
        push_item(OP_ACK, 32'd2);

        // random phases, each under its own register setting
        for (p = 0; p < 9; p++)
        begin
            case (p)
                0:       begin thr = 0;    win = 1;   deb = 0;     budget = 170; end
                1:       begin thr = 4095; win = 0;   deb = 65535; budget = 60;  end
                2:       begin thr = $urandom_range(4095); win = $urandom_range(12, 2);
                               deb = $urandom_range(8, 1); budget = 170; end
                3:       begin thr = 1000; win = 256; deb = 5;     budget = 100; end
                4:       begin thr = $urandom_range(4095); win = $urandom_range(6, 1);
                               deb = 0; budget = 180; end
                5:       begin thr = 4095; win = $urandom_range(10, 2); deb = 3;
                               budget = 150; end
                6:       begin thr = 2000; win = 511; deb = 2;     budget = 100; end
                7:       begin thr = $urandom_range(4095); win = $urandom_range(16, 1);
                               deb = $urandom_range(20, 1); budget = 220; end
                default: begin thr = $urandom_range(4095); win = $urandom_range(5, 2);
                               deb = 4; budget = 180; end
            endcase
            apply_settings(thr, win, deb);
            // first the sender idles rarely, then the receiver, then neither
            send_gap_pct   = (p < 3) ? 18 : (p < 6) ? 70 : 0;
            recv_stall_pct = (p < 3) ? 70 : (p < 6) ? 18 : 0;
            budget_end = item_total + budget;
            while (item_total < budget_end)
                play_shot();
        end

        wait_drained(1);
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_reports.size() == 0)
            $display("light_gun_shot_detector_unit verification clean");
        else
            $display("light_gun_shot_detector_unit verification failed");
        $finish;
    end

endmodule
